FILE: hdl/sld_pkg.sv
package sld_pkg;

    // configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SYNC_VALUE      = 3'd0;
    localparam cfg_idx_t CFG_OWN_ADDRESS     = 3'd1;
    localparam cfg_idx_t CFG_LENGTH_POSITION = 3'd2;
    localparam cfg_idx_t CFG_MIN_LENGTH      = 3'd3;
    localparam cfg_idx_t CFG_MAX_LENGTH      = 3'd4;

    // configuration reset values
    localparam logic [7:0] SYNC_VALUE_RST      = 8'h00;
    localparam logic [7:0] OWN_ADDRESS_RST     = 8'hbb;
    localparam logic [5:0] LENGTH_POSITION_RST = 6'd5;
    localparam logic [6:0] MIN_LENGTH_RST      = 7'd8;
    localparam logic [6:0] MAX_LENGTH_RST      = 7'd64;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_ADDR,
        ST_LEN,
        ST_CHECK,
        ST_BODY,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic fill_clr;     // drop frame, fill count to zero
        logic store_first;  // write byte at offset 0, fill count to one
        logic store;        // write byte at fill count, count up
        logic len_rd;       // read length offset, keep byte for bypass
        logic target_ld;    // latch accepted length
        logic emit_start;   // emit index to zero
        logic emit_rd;      // read store at emit index
        logic out_load;     // load output register, step emit index
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sync_hit;
        logic addr_hit;
        logic fill_full;
        logic len_due;
        logic len_ok;
        logic body_done;
        logic emit_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: hdl/sld_ctrl.sv
module sld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sld_pkg::dp_sts_t sts,
    output sld_pkg::dp_cmd_t cmd
);
    import sld_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_HUNT1:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.sync_hit)
                    begin
                        cmd.store_first = 1'b1;
                        state_next      = ST_HUNT2;
                    end
                    else
                    begin
                        cmd.fill_clr = 1'b1;
                    end
                end
            end
            ST_HUNT2:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.sync_hit)
                    begin
                        cmd.store  = 1'b1;
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                end
            end
            ST_ADDR:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.addr_hit)
                    begin
                        cmd.store  = 1'b1;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                end
            end
            ST_LEN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.fill_full)
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                    else
                    begin
                        cmd.store  = 1'b1;
                        cmd.len_rd = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.len_due)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.target_ld = 1'b1;
                        state_next    = ST_BODY;
                    end
                    else
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                end
                else if (sts.fill_full)
                begin
                    cmd.fill_clr = 1'b1;
                    state_next   = ST_HUNT1;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_BODY:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.fill_full)
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.body_done)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = ST_HUNT1;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase
    end

endmodule

FILE: hdl/sld_dp.sv
module sld_dp #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sld_pkg::dp_cmd_t     cmd,
    output sld_pkg::dp_sts_t     sts,
    input  logic                 cfg_valid,
    input  sld_pkg::cfg_idx_t    cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           frame_byte,
    output logic [5:0]           byte_position,
    output logic                 frame_end
);
    import sld_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);

    logic [7:0]    sync_value_reg;
    logic [7:0]    own_address_reg;
    logic [5:0]    length_position_reg;
    logic [6:0]    min_length_reg;
    logic [6:0]    max_length_reg;

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] target_reg;
    logic [AW-1:0] emit_idx_reg;
    logic          hit_reg;
    logic [7:0]    byte_reg;
    logic          out_valid_reg;
    logic [7:0]    frame_byte_reg;
    logic [5:0]    byte_position_reg;
    logic          frame_end_reg;

    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    len_value;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg      <= SYNC_VALUE_RST;
            own_address_reg     <= OWN_ADDRESS_RST;
            length_position_reg <= LENGTH_POSITION_RST;
            min_length_reg      <= MIN_LENGTH_RST;
            max_length_reg      <= MAX_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_VALUE:      sync_value_reg      <= cfg_data;
                CFG_OWN_ADDRESS:     own_address_reg     <= cfg_data;
                CFG_LENGTH_POSITION: length_position_reg <= cfg_data[5:0];
                CFG_MIN_LENGTH:      min_length_reg      <= cfg_data[6:0];
                CFG_MAX_LENGTH:      max_length_reg      <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clr)
        begin
            fill_next = '0;
        end
        else if (cmd.store_first)
        begin
            fill_next = FW'(1);
        end
        else if (cmd.store)
        begin
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            target_reg    <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.target_ld)
            begin
                target_reg <= len_value[FW-1:0];
            end
            if (cmd.emit_start)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.out_load)
            begin
                emit_idx_reg <= emit_idx_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // frame store, one write and one registered read port
    assign wr_en   = cmd.store || cmd.store_first;
    assign wr_addr = cmd.store_first ? '0 : fill_reg[AW-1:0];
    assign rd_en   = cmd.len_rd || cmd.emit_rd;
    assign rd_addr = cmd.len_rd ? length_position_reg[AW-1:0] : emit_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // length byte bypass: read returns old data when it hits the write
    always_ff @(posedge clk)
    begin
        if (cmd.len_rd)
        begin
            byte_reg <= rx_byte;
            hit_reg  <= (7'(length_position_reg) == 7'(fill_reg));
        end
        if (cmd.out_load)
        begin
            frame_byte_reg    <= rd_data_reg;
            byte_position_reg <= 6'(emit_idx_reg);
            frame_end_reg     <= sts.emit_last;
        end
    end

    assign len_value = hit_reg ? byte_reg : rd_data_reg;

    always_comb
    begin
        sts.sync_hit  = (rx_byte == sync_value_reg);
        sts.addr_hit  = (rx_byte == own_address_reg);
        sts.fill_full = (fill_reg >= FW'(BUF_DEPTH));
        sts.len_due   = (7'(length_position_reg) < 7'(fill_reg));
        sts.len_ok    = (len_value >= {1'b0, min_length_reg})
                     && (len_value <= {1'b0, max_length_reg})
                     && (len_value <= 8'(BUF_DEPTH))
                     && (len_value > 8'(fill_reg));
        sts.body_done = ((fill_reg + FW'(1)) == target_reg);
        sts.emit_last = ((FW'(emit_idx_reg) + FW'(1)) == fill_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_position = byte_position_reg;
    assign frame_end     = frame_end_reg;

    // no overwrite of a result not yet taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    // stores stay inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (fill_reg < FW'(BUF_DEPTH)))
        else $error("store beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(BUF_DEPTH))
        else $error("fill count beyond buffer depth");

    // a loaded length always completes within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.target_ld |=> (target_reg > fill_reg) && (target_reg <= FW'(BUF_DEPTH)))
        else $error("accepted length cannot complete");

endmodule

FILE: hdl/sync_length_packet_deframer.sv
// Sync/length framed packet receiver.
//
// Input channel (in_valid/in_ready/rx_byte): one received byte per transfer.
// The block hunts for two bytes equal to the sync register, then an address
// byte equal to own_address, then collects bytes until the length byte at
// length_position is in. A length outside [min_length, max_length], above
// the buffer depth, or too small to complete drops the frame and the hunt
// restarts. Bytes are taken one per cycle while hunting and in the body;
// up to the length byte each byte is stored, then the registered read of
// the length offset and the range check run before the next byte is taken.
// Output channel (out_valid/out_ready): once the stated length is in, the
// stored frame is sent byte by byte with byte_position and frame_end on the
// last byte. Each byte is read from the single read port of the frame store
// and then loaded into the output register, and the next read starts only
// after that load. Input is not taken while a frame is sent; the last byte
// waits in the output register while the next input is accepted. A stall on
// out_ready holds the output register and the send sequencer.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready.
// Reset: registers to their defaults, hunt for the first sync byte.
module sync_length_packet_deframer #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic [5:0]  byte_position,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import sld_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // config writes are registered directly and never stall
    assign cfg_ready = 1'b1;

    // frame sequencer: hunt, length check, body collect, send
    sld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // config registers, frame store, counters, output register
    sld_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_idx_t'(cfg_index)),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_end     (frame_end)
    );

endmodule

FILE: dv/sld_frame_checker.sv
module sld_frame_checker #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        frame_byte,
    input  logic [5:0]        byte_position,
    input  logic              frame_end,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  sld_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]        cfg_data,
    output int                mismatches,
    output int                beats_due,
    output int                frames_done
);
    timeunit 1ns;
    timeprecision 1ps;
    import sld_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic       last;
    } frame_beat_t;

    typedef enum logic [2:0] {
        SEEK_SYNC_A,
        SEEK_SYNC_B,
        SEEK_ADDR,
        FILL_TO_LEN,
        FILL_TO_END
    } hunt_t;

    // register copies, updated on config transfers
    logic [7:0] sync_q;
    logic [7:0] addr_q;
    logic [5:0] len_pos_q;
    logic [6:0] min_q;
    logic [6:0] max_q;

    hunt_t       hunt;
    int          fill;
    int          want_len;
    logic [7:0]  frame_mem [DEPTH];
    frame_beat_t beats_q [$];
    int          errs;
    int          nframes;

    assign mismatches  = errs;
    assign frames_done = nframes;

    function automatic void drop_frame();
        fill     = 0;
        want_len = 0;
        hunt     = SEEK_SYNC_A;
    endfunction

    function automatic void keep_byte(input logic [7:0] b);
        if (fill < DEPTH)
        begin
            frame_mem[fill] = b;
            fill++;
        end
    endfunction

    task automatic take_byte(input logic [7:0] b);
        int          len;
        frame_beat_t beat;
        case (hunt)
            SEEK_SYNC_B:
            begin
                if (b == sync_q)
                begin
                    keep_byte(b);
                    hunt = SEEK_ADDR;
                end
                else
                begin
                    drop_frame();
                end
            end
            SEEK_ADDR:
            begin
                if (b == addr_q)
                begin
                    keep_byte(b);
                    hunt = FILL_TO_LEN;
                end
                else
                begin
                    drop_frame();
                end
            end
            FILL_TO_LEN:
            begin
                if (fill >= DEPTH)
                begin
                    drop_frame();
                end
                else
                begin
                    keep_byte(b);
                    if (fill > int'(len_pos_q))
                    begin
                        len = frame_mem[int'(len_pos_q) % DEPTH];
                        if (len >= min_q && len <= max_q && len <= DEPTH && len > fill)
                        begin
                            want_len = len;
                            hunt     = FILL_TO_END;
                        end
                        else
                        begin
                            drop_frame();
                        end
                    end
                    else if (fill >= DEPTH)
                    begin
                        drop_frame();
                    end
                end
            end
            FILL_TO_END:
            begin
                if (fill >= DEPTH)
                begin
                    drop_frame();
                end
                else
                begin
                    keep_byte(b);
                    if (fill == want_len)
                    begin
                        for (int i = 0; i < fill; i++)
                        begin
                            beat.data = frame_mem[i];
                            beat.pos  = 6'(i);
                            beat.last = (i + 1 == fill);
                            beats_q.push_back(beat);
                        end
                        drop_frame();
                    end
                end
            end
            default:
            begin
                // a sync byte always starts a fresh frame
                if (b == sync_q)
                begin
                    fill = 0;
                    keep_byte(b);
                    hunt = SEEK_SYNC_B;
                end
                else
                begin
                    drop_frame();
                end
            end
        endcase
    endtask

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        errs++;
        $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_beat_t want;
        if (!rst_n)
        begin
            sync_q    = SYNC_VALUE_RST;
            addr_q    = OWN_ADDRESS_RST;
            len_pos_q = LENGTH_POSITION_RST;
            min_q     = MIN_LENGTH_RST;
            max_q     = MAX_LENGTH_RST;
            drop_frame();
            beats_q.delete();
            errs      = 0;
            nframes   = 0;
            beats_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (beats_q.size() == 0)
                begin
                    errs++;
                    $display("%0d ns: frame byte 0x%0h at offset %0d, expected none",
                             $time, frame_byte, byte_position);
                end
                else
                begin
                    want = beats_q.pop_front();
                    if (frame_byte !== want.data)
                        report("frame_byte", want.data, frame_byte);
                    if (byte_position !== want.pos)
                        report("byte_position", 8'(want.pos), 8'(byte_position));
                    if (frame_end !== want.last)
                        report("frame_end", 8'(want.last), 8'(frame_end));
                    if (want.last)
                        nframes++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_VALUE:      sync_q    = cfg_data;
                    CFG_OWN_ADDRESS:     addr_q    = cfg_data;
                    CFG_LENGTH_POSITION: len_pos_q = cfg_data[5:0];
                    CFG_MIN_LENGTH:      min_q     = cfg_data[6:0];
                    CFG_MAX_LENGTH:      max_q     = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_byte(rx_byte);
            beats_due <= beats_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sld_pkg::*;

    // index with no register behind it; writes must be ignored
    localparam cfg_idx_t CFG_SPARE = 3'd7;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 8;     // covers store + length check after the last byte
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_HEAVY    = 47;
    localparam int IDLE_BOTH     = 24;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte       = 8'h00;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] frame_byte;
    logic [5:0] byte_position;
    logic       frame_end;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index     = CFG_SYNC_VALUE;
    logic [7:0] cfg_data      = 8'h00;

    int mismatches;
    int beats_due;
    int frames_done;

    // stimulus knobs and the register values last written
    int         idle_pct  = 0;
    int         stall_pct = 0;
    logic [7:0] cur_sync;
    logic [7:0] cur_addr;
    int         cur_pos;
    int         cur_min;
    int         cur_max;
    int         bytes_sent    = 0;
    int         settings_done = 0;
    int         quiet         = 0;

    always #1 clk = ~clk;

    sync_length_packet_deframer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sld_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_due     (beats_due),
        .frames_done   (frames_done)
    );

    // Receiver side: one draw per cycle, so stalls land on every emit phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0d ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("sync_length_packet_deframer test failed");
                $finish;
            end
        end
    end

    // One input transfer. in_valid is only dropped for a gap, never between
    // back-to-back bytes, so it gets one update per edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Block is idle once every predicted frame byte is out and the
    // length check on the last byte has had time to run.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays up across a burst of writes
    task automatic cfg_xfer(input cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Unused upper data bits are randomized; the narrow registers drop them.
    task automatic set_registers(input logic [7:0] s, input logic [7:0] a,
                                 input logic [5:0] p, input logic [6:0] mn,
                                 input logic [6:0] mx);
        wait_idle();
        cfg_xfer(CFG_SPARE, 8'($urandom));
        cfg_xfer(CFG_SYNC_VALUE, s);
        cfg_xfer(CFG_OWN_ADDRESS, a);
        cfg_xfer(CFG_LENGTH_POSITION, {2'($urandom), p});
        cfg_xfer(CFG_MIN_LENGTH, {1'($urandom), mn});
        cfg_xfer(CFG_MAX_LENGTH, {1'($urandom), mx});
        cfg_valid <= 1'b0;
        cur_sync = s;
        cur_addr = a;
        cur_pos  = p;
        cur_min  = mn;
        cur_max  = mx;
        settings_done++;
    endtask

    // Mostly well-formed frames for the current registers, with random body.
    // The rest: line noise, a header broken at sync or address, or a length
    // byte that is likely refused. clean always takes the well-formed branch.
    task automatic send_random_frame(input bit clean);
        logic [7:0] seq [$];
        int         kind;
        int         flen;
        int         lo;
        int         hi;
        int         n;
        kind = clean ? 99 : $urandom_range(99);
        seq  = '{cur_sync, cur_sync, cur_addr};
        if (kind < 10)
        begin
            seq.delete();
            n = $urandom_range(4, 1);
            repeat (n) seq.push_back(8'($urandom));
        end
        else if (kind < 20)
        begin
            seq[$urandom_range(2, 1)] = 8'($urandom);
        end
        else
        begin
            if (cur_pos < 3)
            begin
                // length comes from a header byte
                flen = seq[cur_pos];
            end
            else if (kind < 30)
            begin
                flen = $urandom_range(255);
            end
            else
            begin
                lo   = (cur_min > cur_pos + 2) ? cur_min : cur_pos + 2;
                hi   = (cur_max < 64) ? cur_max : 64;
                flen = (lo <= hi) ? $urandom_range(hi, lo) : lo;
            end
            // a refused length only gets a few bytes past the header
            if (flen >= cur_min && flen <= cur_max && flen <= 64 &&
                flen > ((cur_pos + 1 > 4) ? cur_pos + 1 : 4))
                n = flen;
            else
                n = $urandom_range(10, 4);
            while (seq.size() < n)
                seq.push_back(8'($urandom));
            if (cur_pos >= 3 && cur_pos < n)
                seq[cur_pos] = 8'(flen);
        end
        send_seq(seq);
    endtask

    task automatic run_phase(input logic [7:0] s, input logic [7:0] a,
                             input logic [5:0] p, input logic [6:0] mn,
                             input logic [6:0] mx, input int idle,
                             input int stall, input int budget);
        int start;
        set_registers(s, a, p, mn, mx);
        idle_pct  = idle;
        stall_pct <= stall;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_random_frame(1'b0);
    endtask

    initial
    begin : stimulus
        logic [7:0] seq [$];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_sync = SYNC_VALUE_RST;
        cur_addr = OWN_ADDRESS_RST;
        cur_pos  = LENGTH_POSITION_RST;
        cur_min  = MIN_LENGTH_RST;
        cur_max  = MAX_LENGTH_RST;

        // --- directed, starting from reset register values ---
        // shortest legal frame at reset settings, data extremes in the body
        seq = '{8'h00, 8'h00, 8'hbb, 8'hff, 8'h00, 8'h08, 8'ha5, 8'h5a};
        send_seq(seq);
        // second sync missing
        seq = '{8'h00, 8'h01};
        send_seq(seq);
        // wrong address
        seq = '{8'h00, 8'h00, 8'hbc};
        send_seq(seq);

        // length that cannot complete: 6 bytes already in when it is checked
        set_registers(SYNC_VALUE_RST, OWN_ADDRESS_RST, LENGTH_POSITION_RST, 7'd5, MAX_LENGTH_RST);
        seq = '{8'h00, 8'h00, 8'hbb, 8'h11, 8'h22, 8'h06};
        send_seq(seq);

        // length accepted, then length_position moved mid-frame; the
        // latched length must still close the frame at ten bytes
        seq = '{8'h00, 8'h00, 8'hbb, 8'h01, 8'h02, 8'h0a};
        send_seq(seq);
        set_registers(SYNC_VALUE_RST, OWN_ADDRESS_RST, 6'd3, 7'd5, MAX_LENGTH_RST);
        seq = '{8'h03, 8'h04, 8'h05, 8'h06};
        send_seq(seq);

        // --- random phases ---
        // lowest position after the header and minimum length, short frames
        run_phase(8'hff, 8'h00, 6'd3, 7'd5, 7'd9, IDLE_NONE, IDLE_NONE, 2);
        // position 0: length read back from the first sync byte
        run_phase(8'h0a, 8'h55, 6'd0, 7'd5, 7'd127, IDLE_HEAVY, IDLE_NONE, 2);
        // position 1 and 2: length taken from second sync / address
        run_phase(8'($urandom_range(12, 5)), 8'($urandom), 6'd1, 7'd5, 7'd64,
                  IDLE_NONE, IDLE_HEAVY, 2);
        run_phase(8'($urandom), 8'($urandom_range(12, 5)), 6'd2, 7'd5, 7'd64,
                  IDLE_BOTH, IDLE_BOTH, 2);

        // one full-buffer frame, length byte at the last legal offset
        set_registers(8'($urandom), 8'($urandom), 6'd62, 7'd64, 7'd64);
        idle_pct  = IDLE_NONE;
        stall_pct <= IDLE_NONE;
        send_random_frame(1'b1);

        // position 63: no length can ever be accepted
        run_phase(8'($urandom), 8'($urandom), 6'd63, 7'd5, 7'd64, IDLE_HEAVY, IDLE_NONE, 2);
        // anything goes, mostly refused lengths
        run_phase(8'($urandom), 8'($urandom), 6'($urandom_range(10, 3)),
                  7'($urandom_range(127)), 7'($urandom_range(127)), IDLE_BOTH, IDLE_BOTH, 2);
        // single accepted length
        run_phase(8'($urandom), 8'($urandom), 6'd4, 7'd6, 7'd6, IDLE_NONE, IDLE_HEAVY, 2);
        // min above max: every length refused
        run_phase(8'($urandom), 8'($urandom), 6'd3, 7'd64, 7'd5, IDLE_BOTH, IDLE_BOTH, 2);
        run_phase(8'($urandom), 8'($urandom), 6'($urandom_range(6, 3)), 7'd5, 7'd10,
                  IDLE_BOTH, IDLE_BOTH, 8);

        // drain: all predicted frame bytes out, then a short settle
        wait_idle();

        $display("Sent %0d bytes under %0d register settings, with and without gaps and stalls;",
                 bytes_sent, settings_done);
        $display("%0d complete frames checked, %0d mismatches", frames_done, mismatches);
        if (mismatches == 0)
            $display("sync_length_packet_deframer test passed");
        else
            $display("sync_length_packet_deframer test failed");
        $finish;
    end

endmodule

FILE: sync_length_packet_deframer.f
hdl/sld_pkg.sv
hdl/sld_ctrl.sv
hdl/sld_dp.sv
hdl/sync_length_packet_deframer.sv
dv/sld_frame_checker.sv
dv/testbench.sv
